/* rtl/lbp_3x3_window_assert.svh */
// Assertion macros used by the local binary pattern window RTL.
// Needs clk_i and rst_ni in the including module; no other dependencies.
`ifndef LBP_3X3_WINDOW_ASSERT_SVH
`define LBP_3X3_WINDOW_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lbp_pkg.sv */
// Package for the 3x3 local binary pattern block: field widths, reset values,
// register indices and the stage record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbp_pkg;

  localparam int unsigned PIX_W          = 8;
  localparam int unsigned CODE_W         = 8;
  localparam int unsigned FRAME_W_W      = 11;
  localparam int unsigned FRAME_H_W      = 16;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned ROW_W          = FRAME_H_W + 1;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned FRAME_W_RST    = 640;
  localparam int unsigned FRAME_H_RST    = 480;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // Border and emission flags worked out when a transaction is taken.
  typedef struct packed {
    logic emit;
    logic up;
    logic dn;
    logic lf;
    logic rt;
    logic last;
  } step_t;

endpackage

`default_nettype wire

/* rtl/lbp_ram.sv */
// Generic simple dual-port RAM with a registered read port.
// Used for the packed line store that holds two lines; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lbp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/lbp_3x3_window.sv */
// Streaming 3x3 local binary pattern over a raster pixel stream.
// Depends on lbp_pkg, lbp_ram and lbp_3x3_window_assert.svh.
//
// Channel   Direction  Handshake                 Payload
// in        sink       in_valid_i / in_ready_o   pixel_i, is_pad_i
// out       source     out_valid_o / out_ready_i code_o, frame_last_o
// cfg       sink       cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// One transaction per clock while in_ready_o is high; the transaction that completes a
// window sends its code out through the line store read, then the result register.
// The line store read port is used once per pixel, which sets that rate.
// Reset clears counters, window and valid flags; store data read before the current
// frame has written it only meets masked border bits, so there is no clearing pass.
// A stalled output holds the pipeline only when a code is waiting for it.
// Each frame needs frame_width+1 pad transactions to flush its last codes.
`timescale 1ns / 1ps
`default_nettype none
`include "lbp_3x3_window_assert.svh"

module lbp_3x3_window
  import lbp_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [PIX_W-1:0]      pixel_i,
  input  wire logic                  is_pad_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [CODE_W-1:0]     code_o,
  output logic                       frame_last_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned CMPW  = (CW + 1 > FRAME_W_W) ? CW + 1 : FRAME_W_W;
  localparam int unsigned RST_W = (FRAME_W_RST < 2) ? 2 :
                                  ((FRAME_W_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_W_RST);
  localparam logic [CW-1:0]        RST_LAST_COL = CW'(RST_W - 1);
  localparam logic [FRAME_H_W-1:0] RST_LAST_ROW = FRAME_H_W'(FRAME_H_RST - 1);

  // Configuration, held as the last column and last row index.
  logic [CW-1:0]        last_col_q, last_col_d;
  logic [FRAME_H_W-1:0] last_row_q, last_row_d;
  logic [CMPW-1:0]      wcfg;
  logic [FRAME_H_W-1:0] hcfg;
  logic                 cfg_hit;

  // Raster position of the next transaction.
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [ROW_W-1:0] last_row_ext;

  logic flushing, bubble, take, step;
  step_t flags_d;

  // Stage one: transaction waiting for its line store data.
  logic              s1_valid_q, s1_valid_d;
  step_t             s1_q;
  logic [PIX_W-1:0]  s1_pix_q;
  logic [CW-1:0]     s1_col_q;
  logic              s1_go;

  logic [2*PIX_W-1:0] ram_rdata;

  // Window columns: index 1 is left of the centre, index 2 is the centre.
  logic [PIX_W-1:0] win1_q [3];
  logic [PIX_W-1:0] win2_q [3];
  logic [PIX_W-1:0] new_up, new_mid;

  logic [CODE_W-1:0] code_d, code_q;
  logic              last_q;
  logic              out_valid_q, out_valid_d;

  // ---------------------------------------------------------------- config
  assign wcfg = CMPW'(cfg_wdata_i[FRAME_W_W-1:0]);
  assign hcfg = cfg_wdata_i[FRAME_H_W-1:0];

  always_comb begin
    last_col_d = last_col_q;
    last_row_d = last_row_q;
    cfg_hit    = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH: begin
          cfg_hit = 1'b1;
          if (wcfg < CMPW'(2)) begin
            last_col_d = CW'(1);
          end else if (wcfg > CMPW'(MAX_WIDTH)) begin
            last_col_d = CW'(MAX_WIDTH - 1);
          end else begin
            last_col_d = CW'(wcfg - CMPW'(1));
          end
        end
        CFG_FRAME_HEIGHT: begin
          cfg_hit    = 1'b1;
          last_row_d = (hcfg < FRAME_H_W'(2)) ? FRAME_H_W'(1) : hcfg - FRAME_H_W'(1);
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 0
  assign last_row_ext = {1'b0, last_row_q};
  assign flushing     = row_q > last_row_ext;
  assign bubble       = !flushing && is_pad_i;
  assign in_ready_o   = !s1_valid_q || s1_go;
  assign take         = in_valid_i && in_ready_o;
  assign step         = take && !bubble;

  always_comb begin
    flags_d = '0;
    if (col_q == '0) begin
      // Column zero finishes the last pixel of the row two rows up.
      flags_d.emit = row_q >= ROW_W'(2);
      flags_d.up   = row_q >= ROW_W'(3);
      flags_d.dn   = row_q <= last_row_ext + ROW_W'(1);
      flags_d.lf   = 1'b1;
      flags_d.rt   = 1'b0;
      flags_d.last = row_q == last_row_ext + ROW_W'(2);
    end else begin
      flags_d.emit = row_q != '0;
      flags_d.up   = row_q >= ROW_W'(2);
      flags_d.dn   = row_q <= last_row_ext;
      flags_d.lf   = col_q >= CW'(2);
      flags_d.rt   = 1'b1;
      flags_d.last = 1'b0;
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (step) begin
      if (row_q == last_row_ext + ROW_W'(2)) begin
        col_d = '0;
        row_d = '0;
      end else if (col_q == last_col_q) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  assign s1_go      = s1_valid_q && (!s1_q.emit || !out_valid_q || out_ready_i);
  assign s1_valid_d = step || (s1_valid_q && !s1_go);

  // Each entry packs the upper line (high byte) and middle line (low byte).
  lbp_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_go),
    .waddr_i(s1_col_q),
    .wdata_i({ram_rdata[PIX_W-1:0], s1_pix_q}),
    .re_i   (step),
    .raddr_i(col_q),
    .rdata_o(ram_rdata)
  );

  assign new_up  = ram_rdata[2*PIX_W-1:PIX_W];
  assign new_mid = ram_rdata[PIX_W-1:0];

  always_comb begin
    code_d    = '0;
    code_d[7] = s1_q.up && s1_q.lf && (win1_q[0] >= win2_q[1]);
    code_d[6] = s1_q.up && (win2_q[0] >= win2_q[1]);
    code_d[5] = s1_q.up && s1_q.rt && (new_up >= win2_q[1]);
    code_d[4] = s1_q.rt && (new_mid >= win2_q[1]);
    code_d[3] = s1_q.dn && s1_q.rt && (s1_pix_q >= win2_q[1]);
    code_d[2] = s1_q.dn && (win2_q[2] >= win2_q[1]);
    code_d[1] = s1_q.dn && s1_q.lf && (win1_q[2] >= win2_q[1]);
    code_d[0] = s1_q.lf && (win1_q[1] >= win2_q[1]);
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (s1_go && s1_q.emit) begin
      out_valid_d = 1'b1;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q  <= RST_LAST_COL;
      last_row_q  <= RST_LAST_ROW;
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        win1_q[i] <= '0;
        win2_q[i] <= '0;
      end
    end else begin
      last_col_q  <= last_col_d;
      last_row_q  <= last_row_d;
      col_q       <= col_d;
      row_q       <= row_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_go) begin
        win1_q    <= win2_q;
        win2_q[0] <= new_up;
        win2_q[1] <= new_mid;
        win2_q[2] <= s1_pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      s1_q     <= flags_d;
      s1_pix_q <= flushing ? '0 : pixel_i;
      s1_col_q <= col_q;
    end
    if (s1_go && s1_q.emit) begin
      code_q <= code_d;
      last_q <= s1_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_o       = code_q;
  assign frame_last_o = last_q;

  // ---------------------------------------------------------------- checks
  `LBP_ASSERT_SAME(a_col_in_row, 1'b1, col_q <= last_col_q, "column beyond row end")
  `LBP_ASSERT_SAME(a_flush_end, row_q == last_row_ext + ROW_W'(2), col_q == '0,
                   "flush row ran past its single item")
  `LBP_ASSERT_SAME(a_no_overwrite, out_valid_q && !out_ready_i, !(s1_go && s1_q.emit),
                   "waiting code overwritten")
  `LBP_ASSERT_SAME(a_stall_cause, !in_ready_o, s1_valid_q && s1_q.emit && out_valid_q,
                   "input stalled without a waiting code")
  `LBP_ASSERT_NEXT(a_step_reaches_s1, step, s1_valid_q, "accepted pixel lost before stage one")

endmodule

`default_nettype wire
